// ===== sv/sle_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sle_pkg: shared definitions for the scancode line editor
// Scancode constants, event codes, result record and the set-1 key tables.
// ---------------------------------------------------------------------------
package sle_pkg;

   // Line buffer depth; the effective capacity never exceeds min(depth, 256)
   localparam int LINE_DEPTH = 256;
   localparam logic [8:0] CAP_TOP = (LINE_DEPTH > 256) ? 9'd256 : 9'(LINE_DEPTH);
   localparam logic [8:0] CAP_RESET = 9'd256;

   localparam logic [7:0] CODE_LSHIFT_MAKE  = 8'h2A;
   localparam logic [7:0] CODE_RSHIFT_MAKE  = 8'h36;
   localparam logic [7:0] CODE_LSHIFT_BREAK = 8'hAA;
   localparam logic [7:0] CODE_RSHIFT_BREAK = 8'hB6;
   localparam logic [7:0] CODE_ENTER        = 8'h1C;
   localparam logic [7:0] CODE_BACKSPACE    = 8'h0E;
   localparam logic [7:0] MAP_SIZE          = 8'd58;

   localparam logic [6:0] ECHO_BACKSPACE = 7'h08;
   localparam logic [6:0] ECHO_LINEFEED  = 7'h0A;

   typedef enum logic [1:0] {
      EV_APPEND = 2'd0,
      EV_REMOVE = 2'd1,
      EV_END    = 2'd2
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [6:0]     echo;
      logic [6:0]     store;
      logic [7:0]     pos;
   } result_type;

   function automatic logic [6:0] lower_char(input logic [5:0] idx);
      logic [6:0] c;
      case (idx)
         6'd2:  c = 7'h31;  6'd3:  c = 7'h32;  6'd4:  c = 7'h33;  6'd5:  c = 7'h34;
         6'd6:  c = 7'h35;  6'd7:  c = 7'h36;  6'd8:  c = 7'h37;  6'd9:  c = 7'h38;
         6'd10: c = 7'h39;  6'd11: c = 7'h30;  6'd12: c = 7'h2D;  6'd13: c = 7'h3D;
         6'd16: c = 7'h71;  6'd17: c = 7'h77;  6'd18: c = 7'h65;  6'd19: c = 7'h72;
         6'd20: c = 7'h74;  6'd21: c = 7'h79;  6'd22: c = 7'h75;  6'd23: c = 7'h69;
         6'd24: c = 7'h6F;  6'd25: c = 7'h70;  6'd26: c = 7'h5B;  6'd27: c = 7'h5D;
         6'd30: c = 7'h61;  6'd31: c = 7'h73;  6'd32: c = 7'h64;  6'd33: c = 7'h66;
         6'd34: c = 7'h67;  6'd35: c = 7'h68;  6'd36: c = 7'h6A;  6'd37: c = 7'h6B;
         6'd38: c = 7'h6C;  6'd39: c = 7'h3B;  6'd40: c = 7'h27;  6'd41: c = 7'h60;
         6'd43: c = 7'h5C;  6'd44: c = 7'h7A;  6'd45: c = 7'h78;  6'd46: c = 7'h63;
         6'd47: c = 7'h76;  6'd48: c = 7'h62;  6'd49: c = 7'h6E;  6'd50: c = 7'h6D;
         6'd51: c = 7'h2C;  6'd52: c = 7'h2E;  6'd53: c = 7'h2F;  6'd55: c = 7'h2A;
         6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] upper_char(input logic [5:0] idx);
      logic [6:0] c;
      case (idx)
         6'd2:  c = 7'h21;  6'd3:  c = 7'h40;  6'd4:  c = 7'h23;  6'd5:  c = 7'h24;
         6'd6:  c = 7'h25;  6'd7:  c = 7'h5E;  6'd8:  c = 7'h26;  6'd9:  c = 7'h2A;
         6'd10: c = 7'h28;  6'd11: c = 7'h29;  6'd12: c = 7'h5F;  6'd13: c = 7'h2B;
         6'd16: c = 7'h51;  6'd17: c = 7'h57;  6'd18: c = 7'h45;  6'd19: c = 7'h52;
         6'd20: c = 7'h54;  6'd21: c = 7'h59;  6'd22: c = 7'h55;  6'd23: c = 7'h49;
         6'd24: c = 7'h4F;  6'd25: c = 7'h50;  6'd26: c = 7'h7B;  6'd27: c = 7'h7D;
         6'd30: c = 7'h41;  6'd31: c = 7'h53;  6'd32: c = 7'h44;  6'd33: c = 7'h46;
         6'd34: c = 7'h47;  6'd35: c = 7'h48;  6'd36: c = 7'h4A;  6'd37: c = 7'h4B;
         6'd38: c = 7'h4C;  6'd39: c = 7'h3A;  6'd40: c = 7'h22;  6'd41: c = 7'h7E;
         6'd43: c = 7'h7C;  6'd44: c = 7'h5A;  6'd45: c = 7'h58;  6'd46: c = 7'h43;
         6'd47: c = 7'h56;  6'd48: c = 7'h42;  6'd49: c = 7'h4E;  6'd50: c = 7'h4D;
         6'd51: c = 7'h3C;  6'd52: c = 7'h3E;  6'd53: c = 7'h3F;  6'd55: c = 7'h2A;
         6'd57: c = 7'h20;
         default: c = 7'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== sv/scancode_line_editor.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// scancode_line_editor: set-1 scancode to line editing events
// Tracks shift, maps keys to ASCII and emits append / remove / end events.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid, req_stall | req_scancode[7:0]
//  rsp     | out       | rsp_valid, rsp_stall | event_kind, echo, store, position
//  csr     | in        | csr_wr_en            | csr_wr_data[8:0] (line capacity)
//
//  One scancode per cycle while req_stall is low; its result is registered.
//  Shift and fill index update in the cycle of the transfer, so items chain freely.
//  A two-deep output (result register plus skid register) absorbs rsp_stall;
//  req_stall rises only when both are full.
//  Synchronous reset clears shift, fill index and output valid flags; capacity resets to 256.
module scancode_line_editor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_scancode,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_event_kind,
   output logic [6:0]      rsp_echo_byte,
   output logic [6:0]      rsp_store_byte,
   output logic [7:0]      rsp_position,
   input  wire logic       csr_wr_en,
   input  wire logic [8:0] csr_wr_data
);

   logic [8:0] capacity_ff;
   logic       shift_ff, shift_in;
   logic [7:0] fill_ff, fill_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   sle_pkg::result_type out_ff, out_in;
   sle_pkg::result_type skid_ff, skid_in;

   logic       req_accept;
   logic       out_free;
   logic       new_valid;
   sle_pkg::result_type new_res;
   logic [6:0] ch;
   logic [8:0] cap_eff;
   logic [8:0] cap_limit;
   logic       mapped;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_free   = !out_valid_ff || !rsp_stall;

   // clamp capacity to 1..CAP_TOP; a line keeps at most capacity-1 characters
   always_comb begin
      if (capacity_ff > sle_pkg::CAP_TOP) begin
         cap_eff = sle_pkg::CAP_TOP;
      end else if (capacity_ff == 9'd0) begin
         cap_eff = 9'd1;
      end else begin
         cap_eff = capacity_ff;
      end
      cap_limit = cap_eff - 9'd1;
   end

   assign mapped = (req_scancode < sle_pkg::MAP_SIZE);
   assign ch = shift_ff ? sle_pkg::upper_char(req_scancode[5:0])
                        : sle_pkg::lower_char(req_scancode[5:0]);

   always_comb begin
      shift_in      = shift_ff;
      fill_in       = fill_ff;
      new_valid     = 1'b0;
      new_res.kind  = sle_pkg::EV_APPEND;
      new_res.echo  = ch;
      new_res.store = ch;
      new_res.pos   = fill_ff;
      if (req_accept) begin
         if (req_scancode == sle_pkg::CODE_LSHIFT_MAKE ||
             req_scancode == sle_pkg::CODE_RSHIFT_MAKE) begin
            shift_in = 1'b1;
         end else if (req_scancode == sle_pkg::CODE_LSHIFT_BREAK ||
                      req_scancode == sle_pkg::CODE_RSHIFT_BREAK) begin
            shift_in = 1'b0;
         end else if (req_scancode[7]) begin
            // other releases are ignored
         end else if (req_scancode == sle_pkg::CODE_ENTER) begin
            new_valid     = 1'b1;
            new_res.kind  = sle_pkg::EV_END;
            new_res.echo  = sle_pkg::ECHO_LINEFEED;
            new_res.store = 7'd0;
            fill_in       = 8'd0;
            shift_in      = 1'b0;
         end else if (req_scancode == sle_pkg::CODE_BACKSPACE) begin
            if (fill_ff != 8'd0) begin
               new_valid     = 1'b1;
               new_res.kind  = sle_pkg::EV_REMOVE;
               new_res.echo  = sle_pkg::ECHO_BACKSPACE;
               new_res.store = 7'd0;
               new_res.pos   = fill_ff - 8'd1;
               fill_in       = fill_ff - 8'd1;
            end
         end else if (mapped && ch != 7'd0 && {1'b0, fill_ff} < cap_limit) begin
            new_valid = 1'b1;
            fill_in   = fill_ff + 8'd1;
         end
      end
   end

   // result register with a skid stage behind it; order is out, then skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = new_res;
            out_valid_in = new_valid;
         end
      end else if (new_valid) begin
         skid_in       = new_res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= sle_pkg::CAP_RESET;
         shift_ff      <= 1'b0;
         fill_ff       <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         shift_ff      <= shift_in;
         fill_ff       <= fill_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_ff.kind;
   assign rsp_echo_byte  = out_ff.echo;
   assign rsp_store_byte = out_ff.store;
   assign rsp_position   = out_ff.pos;

   // skid only fills behind a held result
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while result register empty");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_scancode == sle_pkg::CODE_ENTER) |=> (fill_ff == 8'd0 && !shift_ff))
      else $error("line state not cleared after enter");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.kind == sle_pkg::EV_APPEND) |-> (out_ff.echo == out_ff.store))
      else $error("append echo and stored byte differ");

   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_scancode == sle_pkg::CODE_BACKSPACE && fill_ff == 8'd0)
         |=> (fill_ff == 8'd0))
      else $error("backspace on empty line changed fill index");

endmodule
`default_nettype wire
